// ===== rtl/att_response_validator_defines.svh =====
// Assertion macros shared by the validator RTL.
`ifndef ATT_RESPONSE_VALIDATOR_DEFINES_SVH
`define ATT_RESPONSE_VALIDATOR_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define ATTRV_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define ATTRV_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) 1'b1 |-> (cond)) \
		else $error(msg);

`endif

// ===== rtl/attrv_pkg.sv =====
// Types, opcodes and helpers for the ATT response validator.
package attrv_pkg;

	localparam int unsigned CNT_W = 10;
	localparam int unsigned MTU_W = 10;

	localparam logic [CNT_W-1:0] MAX_PDU_BYTES = 10'd517;
	localparam logic [MTU_W-1:0] LOCAL_MTU_RESET = 10'd23;
	localparam logic [15:0] ATT_MTU_MIN = 16'd23;

	// Transaction kinds on the input channel
	localparam logic [1:0] REQ_ARM = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	// Discovery attribute types
	localparam logic [1:0] ATTR_OTHER = 2'd0;
	localparam logic [1:0] ATTR_CHAR_DECL = 2'd1;
	localparam logic [1:0] ATTR_CCCD = 2'd2;
	localparam logic [1:0] ATTR_USER_DESC = 2'd3;

	// Read-multiple-variable tuple walk
	localparam logic [1:0] TUPLE_LEN_LO = 2'd0;
	localparam logic [1:0] TUPLE_LEN_HI = 2'd1;
	localparam logic [1:0] TUPLE_VALUE = 2'd2;

	// ATT response opcodes
	localparam logic [7:0] OP_ERROR = 8'h01;
	localparam logic [7:0] OP_MTU = 8'h03;
	localparam logic [7:0] OP_FIND_INFO = 8'h05;
	localparam logic [7:0] OP_FIND_BY_VALUE = 8'h07;
	localparam logic [7:0] OP_READ_BY_TYPE = 8'h09;
	localparam logic [7:0] OP_READ = 8'h0B;
	localparam logic [7:0] OP_READ_BLOB = 8'h0D;
	localparam logic [7:0] OP_READ_MULTI = 8'h0F;
	localparam logic [7:0] OP_READ_BY_GROUP = 8'h11;
	localparam logic [7:0] OP_WRITE = 8'h13;
	localparam logic [7:0] OP_PREPARE_WRITE = 8'h17;
	localparam logic [7:0] OP_EXECUTE_WRITE = 8'h19;
	localparam logic [7:0] OP_READ_MULTI_VAR = 8'h21;

	// Find-information formats and element strides
	localparam logic [7:0] FMT_UUID16 = 8'd1;
	localparam logic [7:0] FMT_UUID128 = 8'd2;
	localparam logic [7:0] STRIDE_UUID16 = 8'd4;
	localparam logic [7:0] STRIDE_UUID128 = 8'd18;
	localparam logic [7:0] STRIDE_HANDLES = 8'd4;

	// Element lengths allowed per attribute type, and for read-by-group elements
	localparam logic [7:0] ELEN_CHAR_16 = 8'd7;
	localparam logic [7:0] ELEN_CHAR_128 = 8'd21;
	localparam logic [7:0] ELEN_CCCD = 8'd4;
	localparam logic [7:0] ELEN_GROUP_16 = 8'd6;
	localparam logic [7:0] ELEN_GROUP_128 = 8'd20;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_NOT_PENDING = 2'd1,
		VERDICT_MISMATCH = 2'd2,
		VERDICT_MALFORMED = 2'd3
	} verdict_t;

	typedef struct packed {
		logic pending;
		logic timed_out;
		logic [7:0] exp_req_opcode;
		logic [7:0] exp_rsp_opcode;
		logic [1:0] attr_type;
	} attrv_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] byte_count;
		logic [7:0] latched_opcode;
		logic [7:0] second_byte;
		logic [7:0] field_low_byte;
		logic [7:0] element_phase;
		logic [15:0] tuple_remaining;
		logic [1:0] tuple_phase;
		logic [7:0] held_error_code;
		logic malformed;
	} attrv_pdu_t;

	typedef struct packed {
		attrv_ctrl_t ctrl;
		attrv_pdu_t pdu;
	} attrv_state_t;

	typedef struct packed {
		logic emit;
		verdict_t verdict;
		logic [7:0] opcode;
		logic [MTU_W-1:0] mtu;
		logic [7:0] err;
		logic [7:0] elen;
	} attrv_result_t;

	// Element stride for opcodes whose payload is a run of fixed-size elements
	function automatic logic [7:0] stride_of(input logic [7:0] op, input logic [7:0] sb);
		logic [7:0] s;
		s = 8'd0;
		if (op == OP_FIND_INFO) begin
			if (sb == FMT_UUID16) s = STRIDE_UUID16;
			else if (sb == FMT_UUID128) s = STRIDE_UUID128;
		end else if (op == OP_FIND_BY_VALUE) begin
			s = STRIDE_HANDLES;
		end else if (op == OP_READ_BY_TYPE || op == OP_READ_BY_GROUP) begin
			s = sb;
		end
		return s;
	endfunction

endpackage

// ===== rtl/att_response_validator.sv =====
// Top level of the ATT response validator.
// Checks the response PDU of the one outstanding ATT request of a single connection,
// one byte per transaction. Input transactions are arm (load the expected request and
// response opcodes and the attribute type), PDU byte, or timeout; only the byte marked
// last yields a result, carrying the verdict, the opcode and the MTU, error code and
// element length fields. The block takes one input transaction per clock cycle while the
// input is not stalled: each transaction is registered in the input register, then checked
// and the per-PDU counters updated combinationally, and the result is captured in the
// output register. The per-byte update of the byte and element counters is the loop that
// sets this rate. The output register decouples the sides; the input stalls only while a
// result waits on a stalled output. local_mtu must be written only while idle; the block
// does not enforce this. It resets to 23. No clearing pass follows reset.
`include "att_response_validator_defines.svh"

module att_response_validator import attrv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic local_mtu_we,
	input logic [MTU_W-1:0] local_mtu_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] req_type,
	input logic [7:0] pdu_byte,
	input logic last_byte,
	input logic [7:0] arm_request_opcode,
	input logic [7:0] arm_response_opcode,
	input logic [1:0] arm_attribute_type,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] verdict,
	output logic [7:0] response_opcode,
	output logic [MTU_W-1:0] negotiated_mtu,
	output logic [7:0] error_code,
	output logic [7:0] element_length
);

	logic [MTU_W-1:0] local_mtu_q;
	logic valid_s1;
	logic [1:0] req_type_s1;
	logic [7:0] pdu_byte_s1;
	logic last_byte_s1;
	logic [7:0] arm_req_s1;
	logic [7:0] arm_rsp_s1;
	logic [1:0] arm_attr_s1;
	attrv_state_t state_q;
	attrv_state_t state_next;
	attrv_result_t result;
	attrv_result_t res_q;
	logic out_valid_q;
	logic advance;

	// Stage 1 moves on unless a result still sits on a stalled output
	assign advance = !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mtu_q <= LOCAL_MTU_RESET;
		end else if (local_mtu_we) begin
			local_mtu_q <= local_mtu_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			pdu_byte_s1 <= pdu_byte;
			last_byte_s1 <= last_byte;
			arm_req_s1 <= arm_request_opcode;
			arm_rsp_s1 <= arm_response_opcode;
			arm_attr_s1 <= arm_attribute_type;
		end
	end

	attrv_pdu_check u_check (
		.cur(state_q),
		.req_type(req_type_s1),
		.pdu_byte(pdu_byte_s1),
		.last_byte(last_byte_s1),
		.arm_request_opcode(arm_req_s1),
		.arm_response_opcode(arm_rsp_s1),
		.arm_attribute_type(arm_attr_s1),
		.local_mtu(local_mtu_q),
		.nxt(state_next),
		.res(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (valid_s1) state_q <= state_next;
			out_valid_q <= valid_s1 && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.emit) begin
			res_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = res_q.verdict;
	assign response_opcode = res_q.opcode;
	assign negotiated_mtu = res_q.mtu;
	assign error_code = res_q.err;
	assign element_length = res_q.elen;

	`ATTRV_ASSERT_IMP(a_stall_only_when_blocked, in_stall, out_valid_q && out_stall,
		"input stalled without a blocked result")
	`ATTRV_ASSERT_IMP(a_mtu_only_on_accept, out_valid_q && res_q.mtu != '0,
		res_q.verdict == VERDICT_ACCEPT && res_q.opcode == OP_MTU,
		"MTU reported outside an accepted MTU response")
	`ATTRV_ASSERT_IMP(a_err_only_on_accept, out_valid_q && res_q.err != 8'd0,
		res_q.verdict == VERDICT_ACCEPT && res_q.opcode == OP_ERROR,
		"error code reported outside an accepted error response")
	`ATTRV_ASSERT_ALWAYS(a_count_bounded, state_q.pdu.byte_count <= MAX_PDU_BYTES,
		"PDU byte count beyond limit")

endmodule

// ===== rtl/attrv_pdu_check.sv =====
// Per-transaction state update and verdict logic of the ATT response validator.
module attrv_pdu_check import attrv_pkg::*; (
	input attrv_state_t cur,
	input logic [1:0] req_type,
	input logic [7:0] pdu_byte,
	input logic last_byte,
	input logic [7:0] arm_request_opcode,
	input logic [7:0] arm_response_opcode,
	input logic [1:0] arm_attribute_type,
	input logic [MTU_W-1:0] local_mtu,
	output attrv_state_t nxt,
	output attrv_result_t res
);

	function automatic logic pdu_valid(
		input logic [7:0] op,
		input logic [7:0] sb,
		input logic [7:0] lb,
		input logic [CNT_W-1:0] len,
		input logic [7:0] ep,
		input logic [1:0] tphase,
		input logic [1:0] attr
	);
		logic ok;
		ok = 1'b0;
		case (op)
			OP_ERROR: ok = (len == 10'd5);
			OP_MTU: ok = (len == 10'd3) && ({lb, sb} >= ATT_MTU_MIN);
			OP_FIND_INFO: ok = (len >= 10'd3) && (stride_of(op, sb) != 8'd0) && (ep == 8'd0);
			OP_FIND_BY_VALUE: ok = (len >= 10'd2) && (ep == 8'd0);
			OP_READ_BY_TYPE: begin
				if (len < 10'd3 || sb < 8'd2 || ep != 8'd0) ok = 1'b0;
				else if (attr == ATTR_CHAR_DECL) ok = (sb == ELEN_CHAR_16) || (sb == ELEN_CHAR_128);
				else if (attr == ATTR_CCCD) ok = (sb == ELEN_CCCD);
				else if (attr == ATTR_USER_DESC) ok = (sb >= 8'd3);
				else ok = 1'b1;
			end
			OP_READ, OP_READ_BLOB, OP_READ_MULTI: ok = 1'b1;
			OP_READ_BY_GROUP: ok = (len >= 10'd3) && (ep == 8'd0) &&
				((sb == ELEN_GROUP_16) || (sb == ELEN_GROUP_128));
			OP_WRITE, OP_EXECUTE_WRITE: ok = (len == 10'd1);
			OP_PREPARE_WRITE: ok = (len >= 10'd5);
			OP_READ_MULTI_VAR: ok = (len >= 10'd3) && (tphase == TUPLE_LEN_LO);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	logic [7:0] stride;
	logic [7:0] ep_inc;
	logic [15:0] tuple_len;
	logic [15:0] peer_mtu;
	logic elements_started;
	logic ok;

	always_comb begin
		nxt = cur;
		res = '0;
		res.verdict = VERDICT_ACCEPT;
		stride = 8'd0;
		ep_inc = 8'd0;
		tuple_len = 16'd0;
		peer_mtu = 16'd0;
		elements_started = 1'b0;
		ok = 1'b0;
		case (req_type)
			REQ_ARM: begin
				nxt.ctrl.exp_req_opcode = arm_request_opcode;
				nxt.ctrl.exp_rsp_opcode = arm_response_opcode;
				nxt.ctrl.attr_type = arm_attribute_type;
				nxt.ctrl.pending = 1'b1;
				nxt.ctrl.timed_out = 1'b0;
				nxt.pdu = '0;
			end
			REQ_TIMEOUT: begin
				nxt.ctrl.timed_out = 1'b1;
			end
			REQ_BYTE: begin
				if (cur.pdu.byte_count >= MAX_PDU_BYTES) begin
					// drop the byte, the PDU is overlong
					nxt.pdu.malformed = 1'b1;
				end else begin
					if (cur.pdu.byte_count == '0) begin
						nxt.pdu = '0;
						nxt.pdu.latched_opcode = pdu_byte;
					end else begin
						if (cur.pdu.byte_count == 10'd1) nxt.pdu.second_byte = pdu_byte;
						if (cur.pdu.byte_count == 10'd4) nxt.pdu.held_error_code = pdu_byte;
						stride = stride_of(cur.pdu.latched_opcode, nxt.pdu.second_byte);
						elements_started = (cur.pdu.latched_opcode == OP_FIND_BY_VALUE) ||
							(cur.pdu.byte_count >= 10'd2);
						ep_inc = cur.pdu.element_phase + 8'd1;
						if (elements_started && stride != 8'd0)
							nxt.pdu.element_phase = (ep_inc >= stride) ? 8'd0 : ep_inc;
						if (cur.pdu.latched_opcode == OP_READ_MULTI_VAR) begin
							tuple_len = {pdu_byte, cur.pdu.field_low_byte};
							case (cur.pdu.tuple_phase)
								TUPLE_LEN_LO: begin
									nxt.pdu.field_low_byte = pdu_byte;
									nxt.pdu.tuple_phase = TUPLE_LEN_HI;
								end
								TUPLE_LEN_HI: begin
									nxt.pdu.tuple_remaining = tuple_len;
									nxt.pdu.tuple_phase = (tuple_len != 16'd0) ?
										TUPLE_VALUE : TUPLE_LEN_LO;
								end
								default: begin
									nxt.pdu.tuple_remaining = cur.pdu.tuple_remaining - 16'd1;
									if (cur.pdu.tuple_remaining == 16'd1)
										nxt.pdu.tuple_phase = TUPLE_LEN_LO;
								end
							endcase
						end
					end
					nxt.pdu.byte_count = cur.pdu.byte_count + 10'd1;
				end

				if (last_byte) begin
					res.emit = 1'b1;
					res.opcode = nxt.pdu.latched_opcode;
					if ((nxt.pdu.latched_opcode == OP_FIND_INFO ||
						nxt.pdu.latched_opcode == OP_READ_BY_TYPE ||
						nxt.pdu.latched_opcode == OP_READ_BY_GROUP) &&
						nxt.pdu.byte_count >= 10'd2)
						res.elen = nxt.pdu.second_byte;
					ok = !nxt.pdu.malformed && pdu_valid(nxt.pdu.latched_opcode,
						nxt.pdu.second_byte, pdu_byte, nxt.pdu.byte_count,
						nxt.pdu.element_phase, nxt.pdu.tuple_phase, cur.ctrl.attr_type);
					if (!cur.ctrl.pending || cur.ctrl.timed_out) begin
						res.verdict = VERDICT_NOT_PENDING;
					end else if (nxt.pdu.latched_opcode == OP_ERROR) begin
						// error response answers the request opcode at offset 1
						if (nxt.pdu.byte_count < 10'd2) res.verdict = VERDICT_MALFORMED;
						else if (nxt.pdu.second_byte != cur.ctrl.exp_req_opcode)
							res.verdict = VERDICT_MISMATCH;
						else res.verdict = ok ? VERDICT_ACCEPT : VERDICT_MALFORMED;
					end else if (nxt.pdu.latched_opcode != cur.ctrl.exp_rsp_opcode) begin
						res.verdict = VERDICT_MISMATCH;
					end else begin
						res.verdict = ok ? VERDICT_ACCEPT : VERDICT_MALFORMED;
					end

					if (res.verdict == VERDICT_ACCEPT) begin
						nxt.ctrl.pending = 1'b0;
						nxt.ctrl.exp_req_opcode = 8'd0;
						nxt.ctrl.exp_rsp_opcode = 8'd0;
						peer_mtu = {pdu_byte, nxt.pdu.second_byte};
						if (nxt.pdu.latched_opcode == OP_MTU)
							res.mtu = (peer_mtu < {6'd0, local_mtu}) ? peer_mtu[MTU_W-1:0] :
								local_mtu;
						if (nxt.pdu.latched_opcode == OP_ERROR)
							res.err = nxt.pdu.held_error_code;
					end
					nxt.pdu = '0;
				end
			end
			default: ;
		endcase
	end

endmodule
